>>> sv/tss_pkg.sv
// Package: shared types, constants and function codes of the timed scene sequencer.
package tss_pkg;

  localparam int STAGES = 8;
  localparam int STEPS  = 16;
  localparam int SLOTS  = 8;
  localparam int STG_W  = 3;
  localparam int STEP_W = 4;
  localparam int SLOT_W = 3;
  localparam int RANK_W = 4;
  localparam int SOLO_W = 4;
  localparam int FRM_W  = 32;

  typedef enum logic [3:0] {
    FN_TICK     = 4'd0,
    FN_TSTART   = 4'd1,
    FN_TCANCEL  = 4'd2,
    FN_PLAY     = 4'd3,
    FN_STOP     = 4'd4,
    FN_RESET    = 4'd5,
    FN_RESTORE  = 4'd6,
    FN_RECALL   = 4'd7,
    FN_STORE    = 4'd8,
    FN_TAKEOVER = 4'd9,
    FN_LDSTEP   = 4'd10,
    FN_LDSLOT   = 4'd11,
    FN_LDTIMER  = 4'd12
  } func_t;

  localparam logic [1:0] KIND_BYP  = 2'd1;
  localparam logic [1:0] KIND_SOLO = 2'd2;

  localparam logic [1:0] CFG_SEQ_LEN   = 2'd0;
  localparam logic [1:0] CFG_LOOP      = 2'd1;
  localparam logic [1:0] CFG_AFTER_MSK = 2'd2;

  typedef struct packed {
    logic [STAGES-1:0] byp;
    logic [SOLO_W-1:0] solo;
  } scene_t;

  typedef struct packed {
    logic [3:0]        func;
    logic [STG_W-1:0]  stage;
    logic [1:0]        action_kind;
    logic [SLOT_W-1:0] slot;
    logic [FRM_W-1:0]  tick_frames;
    logic [3:0]        step_index;
    logic [3:0]        step_scene;
    logic [FRM_W-1:0]  duration_frames;
    logic [7:0]        scene_bypass;
    logic [3:0]        scene_solo;
  } in_word_t;

  typedef struct packed {
    logic [7:0] eff_bypass;
    logic [3:0] eff_solo;
    logic       is_running;
    logic [3:0] cur_step;
    logic [3:0] cur_scene;
    logic       scene_missing;
    logic       can_restore;
    logic       override_on;
    logic [7:0] timers_active;
    logic       accepted;
  } out_word_t;

  // controller -> datapath commands
  typedef struct packed {
    logic start;     // latch the input word
    logic exec;      // run the one-shot operation of a non-tick word
    logic tk_delta;  // tick: compute and subtract the boundary delta
    logic tk_step;   // tick: step boundary handling
    logic tk_expire; // tick: expire one rank
    logic tk_pack;   // tick: recompact ranks
    logic finish;    // build the result word
  } tss_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic is_tick;
    logic tk_more;    // frames remain and something is live
    logic rank_last;  // expire walk done
  } tss_sts_t;

  function automatic scene_t act(input scene_t s, input logic [STG_W-1:0] st,
                                 input logic [1:0] kind);
    scene_t r;
    r = s;
    if (kind == KIND_SOLO) begin
      r.solo = SOLO_W'(st) + SOLO_W'(1);
    end else begin
      r.byp[st] = 1'b1;
      r.solo    = '0;
    end
    return r;
  endfunction

endpackage

>>> sv/tss_if.sv
// Interface: valid/ready channel carrying one word.
interface tss_if #(type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/tss_ctrl.sv
// Controller: sequences one word through the datapath.
module tss_ctrl
  import tss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     out_busy,
  input  tss_sts_t sts,
  output tss_cmd_t cmd,
  output logic     idle
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DISP   = 7'b0000010,
    S_DELTA  = 7'b0000100,
    S_STEP   = 7'b0001000,
    S_EXPIRE = 7'b0010000,
    S_PACK   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.start = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.is_tick) begin
          state_nxt = S_DELTA;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DELTA: begin
        if (sts.tk_more) begin
          cmd.tk_delta = 1'b1;
          state_nxt    = S_STEP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_STEP: begin
        cmd.tk_step = 1'b1;
        state_nxt   = S_EXPIRE;
      end
      S_EXPIRE: begin
        cmd.tk_expire = 1'b1;
        if (sts.rank_last) state_nxt = S_PACK;
      end
      S_PACK: begin
        cmd.tk_pack = 1'b1;
        state_nxt   = S_DELTA;
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign idle = (state_r == S_IDLE);

endmodule

>>> sv/tss_dp.sv
// Datapath: scene state, timers, step/slot tables and the result builder.
module tss_dp
  import tss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  tss_cmd_t    cmd,
  input  in_word_t    in_word,
  input  logic [4:0]  seq_length,
  input  logic        loop_enable,
  input  logic [7:0]  after_mask,
  output tss_sts_t    sts,
  output out_word_t   res
);

  in_word_t w_r;

  scene_t base_r, seqd_r, ovr_r, saved_r;
  logic   run_r, ovr_on_r, rest_r, miss_r;
  logic [STEP_W-1:0] pos_r;
  logic [3:0]        snow_r;
  logic [FRM_W-1:0]  left_r;
  logic [FRM_W-1:0]  frames_r;

  logic [STAGES-1:0] tk_kind_v_r;
  logic [1:0]        t_kind_r  [STAGES];
  logic              t_after_r [STAGES];
  logic [FRM_W-1:0]  t_left_r  [STAGES];
  logic [RANK_W-1:0] t_rank_r  [STAGES];

  logic [3:0]        st_scene_r [STEPS];
  logic [FRM_W-1:0]  st_dur_r   [STEPS];
  scene_t            slot_r     [SLOTS];
  logic [SLOTS-1:0]  filled_r;
  logic [FRM_W-1:0]  tlen_r     [STAGES];

  logic [RANK_W-1:0] xrank_r;  // rank walk during expiry
  logic              chg_r;

  out_word_t res_r;

  // active mask
  always_comb begin
    for (int i = 0; i < STAGES; i++) tk_kind_v_r[i] = (t_kind_r[i] != 2'd0);
  end

  function automatic scene_t under_f(input logic run, input logic ov,
                                     input scene_t b, input scene_t o, input scene_t s);
    if (!run) return b;
    return ov ? o : s;
  endfunction

  scene_t und;
  assign und = under_f(run_r, ovr_on_r, base_r, ovr_r, seqd_r);

  // effective scene: overlay timers applied in rank order (ranks are compact)
  scene_t eff_s;
  always_comb begin
    eff_s = und;
    for (int r = 1; r <= STAGES; r++) begin
      for (int i = 0; i < STAGES; i++) begin
        if (t_kind_r[i] != 2'd0 && !t_after_r[i] && t_rank_r[i] == RANK_W'(r))
          eff_s = act(eff_s, STG_W'(i), t_kind_r[i]);
      end
    end
  end

  // boundary delta
  logic [FRM_W-1:0] delta;
  always_comb begin
    delta = frames_r;
    if (run_r && left_r < delta) delta = left_r;
    for (int i = 0; i < STAGES; i++)
      if (t_kind_r[i] != 2'd0 && t_left_r[i] < delta) delta = t_left_r[i];
  end

  logic [4:0] used_len;
  always_comb begin
    if (seq_length == 5'd0)            used_len = 5'd1;
    else if (seq_length > 5'(STEPS))   used_len = 5'(STEPS);
    else                               used_len = seq_length;
  end

  logic [4:0] nxt_pos;
  assign nxt_pos = {1'b0, pos_r} + 5'd1;

  logic stage_ok;
  assign stage_ok = 1'b1;  // stage field width equals STAGES range

  logic [3:0] sc_in;
  assign sc_in = w_r.step_scene;

  // entry helper for "enter" with given base under scene
  task automatic do_enter(input logic [STEP_W-1:0] stp, input scene_t u,
                          output scene_t sq, output logic ms,
                          output logic [3:0] sn, output logic [FRM_W-1:0] lf);
    logic [3:0] sc;
    sc = st_scene_r[stp];
    sq = u;
    ms = 1'b0;
    sn = sc;
    lf = (st_dur_r[stp] == '0) ? FRM_W'(1) : st_dur_r[stp];
    if (!sc[3]) begin
      if (filled_r[sc[SLOT_W-1:0]]) sq = slot_r[sc[SLOT_W-1:0]];
      else ms = 1'b1;
    end
  endtask

  assign sts.is_tick   = (w_r.func == FN_TICK);
  assign sts.tk_more   = (frames_r != '0) && (run_r || (|tk_kind_v_r));
  assign sts.rank_last = (xrank_r == RANK_W'(STAGES));

  always_ff @(posedge clk) begin
    scene_t sq, s2;
    logic ms, was;
    logic [3:0] sn;
    logic [FRM_W-1:0] lf;
    logic [RANK_W-1:0] nr;
    logic ok;
    if (!rst_n) begin
      base_r <= '0; seqd_r <= '0; ovr_r <= '0; saved_r <= '0;
      run_r <= 1'b0; ovr_on_r <= 1'b0; rest_r <= 1'b0; miss_r <= 1'b0;
      pos_r <= '0; snow_r <= 4'hF; left_r <= '0; frames_r <= '0;
      filled_r <= '0; xrank_r <= '0; chg_r <= 1'b0;
      for (int i = 0; i < STAGES; i++) begin
        t_kind_r[i] <= '0; t_after_r[i] <= 1'b0; t_left_r[i] <= '0; t_rank_r[i] <= '0;
      end
      for (int i = 0; i < STEPS; i++) st_scene_r[i] <= 4'hF;
      res_r <= '0;
    end else begin
      if (cmd.start) begin
        w_r      <= in_word;
        frames_r <= in_word.tick_frames;
        res_r.accepted <= 1'b1;
      end
      if (cmd.tk_delta) begin
        frames_r <= frames_r - delta;
        if (run_r) left_r <= left_r - delta;
        for (int i = 0; i < STAGES; i++)
          if (t_kind_r[i] != 2'd0) t_left_r[i] <= t_left_r[i] - delta;
        xrank_r <= RANK_W'(1);
        chg_r   <= 1'b0;
      end
      if (cmd.tk_step && run_r && left_r == '0) begin
        if (nxt_pos >= used_len && !loop_enable) begin
          base_r <= und; ovr_on_r <= 1'b0; run_r <= 1'b0; left_r <= '0;
        end else begin
          do_enter((nxt_pos >= used_len) ? '0 : nxt_pos[STEP_W-1:0], und, sq, ms, sn, lf);
          seqd_r <= sq; ovr_on_r <= 1'b0; miss_r <= ms; snow_r <= sn; left_r <= lf;
          pos_r <= (nxt_pos >= used_len) ? '0 : nxt_pos[STEP_W-1:0];
        end
      end
      if (cmd.tk_expire) begin
        // ranks are unique, so at most one timer holds this rank
        for (int i = 0; i < STAGES; i++) begin
          if (t_kind_r[i] != 2'd0 && t_left_r[i] == '0 && t_rank_r[i] == xrank_r) begin
            if (t_after_r[i]) begin
              s2 = act(und, STG_W'(i), t_kind_r[i]);
              if (run_r) begin ovr_r <= s2; ovr_on_r <= 1'b1; end
              else base_r <= s2;
            end
            t_kind_r[i] <= '0;
            chg_r <= 1'b1;
          end
        end
        xrank_r <= xrank_r + RANK_W'(1);
      end
      if (cmd.tk_pack && chg_r) begin
        for (int i = 0; i < STAGES; i++) begin
          if (t_kind_r[i] == 2'd0) begin
            t_after_r[i] <= 1'b0; t_left_r[i] <= '0; t_rank_r[i] <= '0;
          end else begin
            nr = RANK_W'(1);
            for (int j = 0; j < STAGES; j++)
              if (t_kind_r[j] != 2'd0 && t_rank_r[j] < t_rank_r[i]) nr = nr + RANK_W'(1);
            t_rank_r[i] <= nr;
          end
        end
      end
      if (cmd.exec) begin
        ok = 1'b1;
        case (w_r.func)
          FN_TSTART: begin
            if (w_r.action_kind != KIND_BYP && w_r.action_kind != KIND_SOLO) ok = 1'b0;
            else begin
              nr = RANK_W'(1);
              for (int i = 0; i < STAGES; i++) begin
                if (i != int'(w_r.stage) && t_kind_r[i] != 2'd0) begin
                  nr = nr + RANK_W'(1);
                  if (t_rank_r[w_r.stage] != '0 && t_rank_r[i] > t_rank_r[w_r.stage])
                    t_rank_r[i] <= t_rank_r[i] - RANK_W'(1);
                end
              end
              t_kind_r[w_r.stage]  <= w_r.action_kind;
              t_after_r[w_r.stage] <= after_mask[w_r.stage];
              t_left_r[w_r.stage]  <= (tlen_r[w_r.stage] == '0) ? FRM_W'(1)
                                                               : tlen_r[w_r.stage];
              t_rank_r[w_r.stage]  <= nr;
            end
          end
          FN_TCANCEL: begin
            for (int i = 0; i < STAGES; i++)
              if (t_rank_r[w_r.stage] != '0 && t_rank_r[i] > t_rank_r[w_r.stage])
                t_rank_r[i] <= t_rank_r[i] - RANK_W'(1);
            t_kind_r[w_r.stage] <= '0; t_after_r[w_r.stage] <= 1'b0;
            t_left_r[w_r.stage] <= '0; t_rank_r[w_r.stage] <= '0;
          end
          FN_PLAY: begin
            if (!run_r) begin
              saved_r <= base_r; rest_r <= 1'b1; run_r <= 1'b1;
              do_enter('0, base_r, sq, ms, sn, lf);
              seqd_r <= sq; ovr_on_r <= 1'b0; miss_r <= ms; snow_r <= sn;
              left_r <= lf; pos_r <= '0;
            end
          end
          FN_STOP: begin
            base_r <= und; ovr_on_r <= 1'b0; run_r <= 1'b0; left_r <= '0;
          end
          FN_RESET: begin
            was = run_r;
            if (!rest_r) begin saved_r <= base_r; rest_r <= 1'b1; end
            do_enter('0, was ? und : base_r, sq, ms, sn, lf);
            ovr_on_r <= 1'b0; miss_r <= ms; snow_r <= sn; pos_r <= '0;
            if (was) begin seqd_r <= sq; left_r <= lf; end
            else begin base_r <= sq; seqd_r <= sq; left_r <= '0; end
          end
          FN_RESTORE, FN_TAKEOVER: begin
            if (w_r.func == FN_RESTORE && !rest_r) ok = 1'b0;
            else begin
              for (int i = 0; i < STAGES; i++) begin
                t_kind_r[i] <= '0; t_after_r[i] <= 1'b0; t_left_r[i] <= '0; t_rank_r[i] <= '0;
              end
              run_r <= 1'b0; left_r <= '0; ovr_on_r <= 1'b0;
              if (w_r.func == FN_RESTORE) begin
                base_r <= saved_r; rest_r <= 1'b0; pos_r <= '0;
                snow_r <= 4'hF; miss_r <= 1'b0;
              end else begin
                base_r <= eff_s;
              end
            end
          end
          FN_RECALL: begin
            if (!filled_r[w_r.slot]) ok = 1'b0;
            else begin
              for (int i = 0; i < STAGES; i++) begin
                t_kind_r[i] <= '0; t_after_r[i] <= 1'b0; t_left_r[i] <= '0; t_rank_r[i] <= '0;
              end
              if (run_r) begin ovr_r <= slot_r[w_r.slot]; ovr_on_r <= 1'b1; end
              else base_r <= slot_r[w_r.slot];
            end
          end
          FN_STORE: begin
            slot_r[w_r.slot] <= eff_s; filled_r[w_r.slot] <= 1'b1;
          end
          FN_LDSTEP: begin
            st_scene_r[w_r.step_index] <= (sc_in[3] && sc_in != 4'hF) ? 4'hF : sc_in;
            st_dur_r[w_r.step_index] <= (w_r.duration_frames == '0) ? FRM_W'(1)
                                                                     : w_r.duration_frames;
          end
          FN_LDSLOT: begin
            if (w_r.scene_solo > SOLO_W'(STAGES)) begin
              slot_r[w_r.slot] <= '0; filled_r[w_r.slot] <= 1'b0;
            end else begin
              slot_r[w_r.slot] <= {w_r.scene_bypass, w_r.scene_solo};
              filled_r[w_r.slot] <= 1'b1;
            end
          end
          FN_LDTIMER: begin
            if (stage_ok)
              tlen_r[w_r.stage] <= (w_r.duration_frames == '0) ? FRM_W'(1)
                                                               : w_r.duration_frames;
          end
          default: ok = 1'b0;
        endcase
        res_r.accepted <= ok;
      end
      if (cmd.finish) begin
        res_r.eff_bypass    <= eff_s.byp;
        res_r.eff_solo      <= eff_s.solo;
        res_r.is_running    <= run_r;
        res_r.cur_step      <= pos_r;
        res_r.cur_scene     <= snow_r;
        res_r.scene_missing <= miss_r;
        res_r.can_restore   <= rest_r;
        res_r.override_on   <= ovr_on_r;
        res_r.timers_active <= tk_kind_v_r;
      end
    end
  end

  assign res = res_r;

endmodule

>>> sv/timed_scene_sequencer_core.sv
// Top level: timed scene sequencer core.
//
//  channel | dir | handshake     | word
//  in_     | in  | valid/ready   | in_word_t (func, stage, ... scene_solo)
//  out_    | out | valid/ready   | out_word_t (eff_bypass ... accepted)
//  cfg_    | in  | we, no ready  | index 0..2, 8-bit data
//
// One word at a time. A non-tick word is dispatched, executed, then its result is built.
// A tick runs one pass per frame boundary (delta, step, 8-rank expiry walk, rank repack);
// the number of boundaries is set by step ends and timer expiries. The result register
// holds until taken; the next word is accepted only after. Reset is synchronous, active
// low, with no clearing pass; step durations, slot scenes and timer lengths are not reset.
module timed_scene_sequencer_core
  import tss_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  tss_if.sink        in_ch,
  tss_if.source      out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [4:0] seq_length_r;
  logic       loop_enable_r;
  logic [7:0] after_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_length_r  <= 5'd16;
      loop_enable_r <= 1'b1;
      after_mask_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEQ_LEN:   seq_length_r  <= cfg_data[4:0];
        CFG_LOOP:      loop_enable_r <= cfg_data[0];
        CFG_AFTER_MSK: after_mask_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  tss_cmd_t cmd;
  tss_sts_t sts;
  logic     idle;
  logic     out_v_r;
  logic     in_fire;

  assign in_ch.ready = idle && !out_v_r;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n)                           out_v_r <= 1'b0;
    else if (cmd.finish)                  out_v_r <= 1'b1;
    else if (out_ch.ready)                out_v_r <= 1'b0;
  end
  assign out_ch.valid = out_v_r;

  tss_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_busy(out_v_r), .sts, .cmd, .idle
  );

  tss_dp u_dp (
    .clk, .rst_n, .cmd, .in_word(in_ch.data),
    .seq_length(seq_length_r), .loop_enable(loop_enable_r),
    .after_mask(after_mask_r), .sts, .res(out_ch.data)
  );

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !out_v_r) else $error("word accepted while result pending");
  a_finish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_v_r) else $error("result not presented");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd)) else $error("controller issued overlapping commands");
`endif

endmodule

>>> tb/timed_scene_sequencer_core_test.sv
// Testbench: checks the timed scene sequencer core against its own scene/step/timer model.
module timed_scene_sequencer_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tss_pkg::*;

  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int ITEMS_PER_PHASE = 185;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;

  // Result checker: keeps the predicted result words in order.
  class scene_scoreboard;
    out_word_t pending_results[$];
    int errors = 0;

    task report(string msg);
      if (errors < 30) $display("ERROR %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void note_result(out_word_t e);
      pending_results.push_back(e);
    endfunction

    task check_result(out_word_t a);
      out_word_t e;
      if (pending_results.size() == 0) begin
        report("result word with no prediction waiting");
        return;
      end
      e = pending_results.pop_front();
      if (a.eff_bypass !== e.eff_bypass)
        report($sformatf("eff_bypass %h want %h", a.eff_bypass, e.eff_bypass));
      if (a.eff_solo !== e.eff_solo)
        report($sformatf("eff_solo %h want %h", a.eff_solo, e.eff_solo));
      if (a.is_running !== e.is_running)
        report($sformatf("is_running %b want %b", a.is_running, e.is_running));
      if (a.cur_step !== e.cur_step)
        report($sformatf("cur_step %h want %h", a.cur_step, e.cur_step));
      if (a.cur_scene !== e.cur_scene)
        report($sformatf("cur_scene %h want %h", a.cur_scene, e.cur_scene));
      if (a.scene_missing !== e.scene_missing)
        report($sformatf("scene_missing %b want %b", a.scene_missing, e.scene_missing));
      if (a.can_restore !== e.can_restore)
        report($sformatf("can_restore %b want %b", a.can_restore, e.can_restore));
      if (a.override_on !== e.override_on)
        report($sformatf("override_on %b want %b", a.override_on, e.override_on));
      if (a.timers_active !== e.timers_active)
        report($sformatf("timers_active %h want %h", a.timers_active, e.timers_active));
      if (a.accepted !== e.accepted)
        report($sformatf("accepted %b want %b", a.accepted, e.accepted));
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  tss_if #(.T(in_word_t))  in_ch ();
  tss_if #(.T(out_word_t)) out_ch ();

  timed_scene_sequencer_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  scene_scoreboard sb = new();
  int  cycles = 0;
  bit  hold_request = 0;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of everything the block keeps.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [1:0]      kind;   // 0 idle, 1 bypass, 2 solo
    bit              after;  // apply at expiry instead of overlay
    longint unsigned left;
    int              rank;
  } timer_slot_t;

  int              seq_len_reg;
  bit              loop_reg;
  logic [7:0]      after_mask_reg;
  scene_t          base_s, seq_s, ovr_s, saved_s;
  bit              running, ovr_on, restore_ok, missing;
  int              pos, scene_now;
  longint unsigned step_left_frames;
  timer_slot_t     timers [STAGES];
  int              step_scene_tab [STEPS];
  longint unsigned step_dur_tab [STEPS];
  scene_t          slot_tab [SLOTS];
  logic [7:0]      filled;
  longint unsigned timer_len_tab [STAGES];

  function automatic void clear_timers();
    for (int i = 0; i < STAGES; i++) timers[i] = '{2'd0, 1'b0, 64'd0, 0};
  endfunction

  function automatic void model_reset();
    seq_len_reg = 16; loop_reg = 1; after_mask_reg = '0;
    base_s = '0; seq_s = '0; ovr_s = '0; saved_s = '0;
    running = 0; ovr_on = 0; restore_ok = 0; missing = 0;
    pos = 0; scene_now = -1; step_left_frames = 0;
    clear_timers();
    for (int i = 0; i < STEPS; i++) begin
      step_scene_tab[i] = -1; step_dur_tab[i] = 0;
    end
    for (int i = 0; i < SLOTS; i++) slot_tab[i] = '0;
    filled = '0;
    for (int i = 0; i < STAGES; i++) timer_len_tab[i] = 0;
  endfunction

  function automatic scene_t underlying_scene();
    if (!running) return base_s;
    return ovr_on ? ovr_s : seq_s;
  endfunction

  function automatic scene_t with_action(scene_t s, int st, logic [1:0] k);
    scene_t r;
    r = s;
    if (k == KIND_SOLO) r.solo = SOLO_W'(st + 1);
    else begin
      r.byp[st] = 1'b1;
      r.solo = '0;
    end
    return r;
  endfunction

  // overlay timers stack on top of the underlying scene in rank order
  function automatic scene_t live_scene();
    scene_t s;
    s = underlying_scene();
    for (int r = 1; r <= STAGES; r++)
      for (int i = 0; i < STAGES; i++)
        if (timers[i].kind != 0 && !timers[i].after && timers[i].rank == r)
          s = with_action(s, i, timers[i].kind);
    return s;
  endfunction

  function automatic void set_live(scene_t s);
    if (running) begin
      ovr_s = s; ovr_on = 1;
    end else base_s = s;
  endfunction

  function automatic int used_len();
    if (seq_len_reg < 1) return 1;
    if (seq_len_reg > STEPS) return STEPS;
    return seq_len_reg;
  endfunction

  function automatic void open_step(int st);
    seq_s = underlying_scene();
    ovr_on = 0;
    pos = st;
    scene_now = step_scene_tab[st];
    missing = 0;
    step_left_frames = (step_dur_tab[st] != 0) ? step_dur_tab[st] : 1;
    if (scene_now >= 0 && scene_now < SLOTS) begin
      if (filled[scene_now]) seq_s = slot_tab[scene_now];
      else missing = 1;
    end
  endfunction

  function automatic void stop_seq();
    base_s = underlying_scene();
    ovr_on = 0;
    running = 0;
    step_left_frames = 0;
  endfunction

  // drop one timer and close the gap in the rank order
  function automatic void drop_timer(int st);
    int r;
    r = timers[st].rank;
    timers[st] = '{2'd0, 1'b0, 64'd0, 0};
    for (int i = 0; i < STAGES; i++)
      if (r != 0 && timers[i].rank > r) timers[i].rank--;
  endfunction

  function automatic bit any_timer();
    for (int i = 0; i < STAGES; i++) if (timers[i].kind != 0) return 1;
    return 0;
  endfunction

  // consume frames one boundary at a time: step end first, then expiries
  function automatic void run_frames(longint unsigned frames);
    longint unsigned d;
    bit changed;
    int nxt, nr;
    scene_t s;
    while (frames != 0 && (running || any_timer())) begin
      d = frames;
      if (running && step_left_frames < d) d = step_left_frames;
      for (int i = 0; i < STAGES; i++)
        if (timers[i].kind != 0 && timers[i].left < d) d = timers[i].left;
      frames -= d;
      if (running) step_left_frames -= d;
      for (int i = 0; i < STAGES; i++) if (timers[i].kind != 0) timers[i].left -= d;
      changed = 0;
      if (running && step_left_frames == 0) begin
        nxt = pos + 1;
        if (nxt >= used_len()) begin
          if (loop_reg) nxt = 0;
          else stop_seq();
        end
        if (running) open_step(nxt);
      end
      for (int r = 1; r <= STAGES; r++)
        for (int i = 0; i < STAGES; i++)
          if (timers[i].kind != 0 && timers[i].left == 0 && timers[i].rank == r) begin
            if (timers[i].after) begin
              s = with_action(underlying_scene(), i, timers[i].kind);
              set_live(s);
            end
            timers[i].kind = 0;
            changed = 1;
          end
      if (changed) begin
        nr = 1;
        for (int r = 1; r <= STAGES; r++)
          for (int i = 0; i < STAGES; i++)
            if (timers[i].kind != 0 && timers[i].rank == r) begin
              timers[i].rank = nr;
              nr++;
            end
        for (int i = 0; i < STAGES; i++)
          if (timers[i].kind == 0) timers[i] = '{2'd0, 1'b0, 64'd0, 0};
      end
    end
  endfunction

  function automatic void model_config(logic [1:0] idx, logic [7:0] val);
    case (idx)
      CFG_SEQ_LEN:   seq_len_reg = int'(val[4:0]);
      CFG_LOOP:      loop_reg = val[0];
      CFG_AFTER_MSK: after_mask_reg = val;
      default: ;
    endcase
  endfunction

  // apply one input word to the model and return the result word it causes
  function automatic out_word_t predict_scene(in_word_t w);
    out_word_t o;
    bit ok, was;
    int st, sl, sc, r;
    longint unsigned dur;
    scene_t e;
    logic [7:0] tmask;
    ok = 1;
    st = int'(w.stage);
    sl = int'(w.slot);
    sc = int'(w.step_scene);
    if (sc >= 8) sc -= 16;
    dur = (w.duration_frames != 0) ? longint'(w.duration_frames) : 1;
    case (w.func)
      FN_TICK: run_frames(longint'(w.tick_frames));
      FN_TSTART: begin
        if (w.action_kind != KIND_BYP && w.action_kind != KIND_SOLO) ok = 0;
        else begin
          drop_timer(st);
          r = 1;
          for (int i = 0; i < STAGES; i++) if (timers[i].kind != 0) r++;
          timers[st].kind  = w.action_kind;
          timers[st].after = after_mask_reg[st];
          timers[st].left  = (timer_len_tab[st] != 0) ? timer_len_tab[st] : 1;
          timers[st].rank  = r;
        end
      end
      FN_TCANCEL: drop_timer(st);
      FN_PLAY: begin
        if (!running) begin
          saved_s = base_s; restore_ok = 1;
          seq_s = base_s; ovr_on = 0;
          running = 1; open_step(0);
        end
      end
      FN_STOP: stop_seq();
      FN_RESET: begin
        was = running;
        if (!restore_ok) begin
          saved_s = base_s; restore_ok = 1;
        end
        if (!was) begin
          seq_s = base_s; running = 1;
        end
        open_step(0);
        if (!was) stop_seq();
      end
      FN_RESTORE: begin
        if (!restore_ok) ok = 0;
        else begin
          clear_timers();
          running = 0; step_left_frames = 0; ovr_on = 0;
          base_s = saved_s; restore_ok = 0;
          pos = 0; scene_now = -1; missing = 0;
        end
      end
      FN_RECALL: begin
        if (!filled[sl]) ok = 0;
        else begin
          clear_timers();
          set_live(slot_tab[sl]);
        end
      end
      FN_STORE: begin
        slot_tab[sl] = live_scene();
        filled[sl] = 1'b1;
      end
      FN_TAKEOVER: begin
        base_s = live_scene(); clear_timers();
        running = 0; step_left_frames = 0; ovr_on = 0;
      end
      FN_LDSTEP: begin
        step_scene_tab[w.step_index] = (sc >= -1 && sc < SLOTS) ? sc : -1;
        step_dur_tab[w.step_index] = dur;
      end
      FN_LDSLOT: begin
        if (w.scene_solo > STAGES) begin
          slot_tab[sl] = '0;
          filled[sl] = 1'b0;
        end else begin
          slot_tab[sl].byp  = w.scene_bypass;
          slot_tab[sl].solo = w.scene_solo;
          filled[sl] = 1'b1;
        end
      end
      FN_LDTIMER: timer_len_tab[st] = dur;
      default: ok = 0;
    endcase
    e = live_scene();
    tmask = '0;
    for (int i = 0; i < STAGES; i++) if (timers[i].kind != 0) tmask[i] = 1'b1;
    o.eff_bypass    = e.byp;
    o.eff_solo      = e.solo;
    o.is_running    = running;
    o.cur_step      = pos[3:0];
    o.cur_scene     = scene_now[3:0];
    o.scene_missing = missing;
    o.can_restore   = restore_ok;
    o.override_on   = ovr_on;
    o.timers_active = tmask;
    o.accepted      = ok;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_word_t blank_word(logic [3:0] f);
    in_word_t w;
    w = '0;
    w.func = f;
    return w;
  endfunction

  // random word; weighted toward ticks, timers and scene traffic
  function automatic in_word_t random_word();
    in_word_t w;
    int pick;
    w.stage           = STG_W'($urandom);
    w.action_kind     = 2'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(1, 2));
    w.slot            = SLOT_W'($urandom);
    w.step_index      = 4'($urandom);
    w.step_scene      = 4'($urandom);
    w.scene_bypass    = 8'($urandom);
    w.scene_solo      = 4'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 8));
    // mostly short durations so ticks cross few boundaries; some full width
    w.duration_frames = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40);
    // full width ticks only while nothing is live, else the walk gets long
    w.tick_frames     = (running || any_timer()) ? $urandom_range(0, 60) : $urandom;
    pick = $urandom_range(0, 99);
    if      (pick < 33) w.func = FN_TICK;
    else if (pick < 45) w.func = FN_TSTART;
    else if (pick < 50) w.func = FN_TCANCEL;
    else if (pick < 56) w.func = FN_PLAY;
    else if (pick < 60) w.func = FN_STOP;
    else if (pick < 63) w.func = FN_RESET;
    else if (pick < 66) w.func = FN_RESTORE;
    else if (pick < 72) w.func = FN_RECALL;
    else if (pick < 77) w.func = FN_STORE;
    else if (pick < 80) w.func = FN_TAKEOVER;
    else if (pick < 88) w.func = FN_LDSTEP;
    else if (pick < 94) w.func = FN_LDSLOT;
    else if (pick < 98) w.func = FN_LDTIMER;
    else w.func = 4'($urandom_range(13, 15));
    return w;
  endfunction

  int burst_left = 0;

  // offer one word, hold it until taken, predict on acceptance; bursts and gaps
  task automatic send_word(in_word_t w);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_result(predict_scene(w));
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // write enable stays high across back-to-back writes; the caller drops it
  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    model_config(idx, val);
  endtask

  task automatic set_phase(int len, bit lp, logic [7:0] msk);
    wait_drained();
    // upper data bits are don't-care for the narrow registers
    write_reg(CFG_SEQ_LEN, {3'($urandom), 5'(len)});
    write_reg(CFG_LOOP, {7'($urandom), lp});
    write_reg(CFG_AFTER_MSK, msk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready pattern changes mode every so often; one long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int mode, span;
    out_ch.ready <= 1'b0;
    mode = 0;
    span = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (span == 0) begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(20, 200);
      end
      span--;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom);
        default: out_ch.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_word_t w;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    model_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every duration gets a value before anything can read it
    for (int i = 0; i < STEPS; i++) begin
      w = blank_word(FN_LDSTEP);
      w.step_index = 4'(i);
      w.step_scene = 4'(i % 9);
      w.duration_frames = $urandom_range(1, 20);
      send_word(w);
    end
    for (int i = 0; i < STAGES; i++) begin
      w = blank_word(FN_LDTIMER);
      w.stage = 3'(i);
      w.duration_frames = (i == 5) ? 32'd0 : $urandom_range(1, 30);
      send_word(w);
    end

    // directed: rejects, extremes, bad timer kinds, empty slot, unused codes
    send_word(blank_word(FN_RESTORE));                   // nothing saved yet
    w = blank_word(FN_LDSLOT); w.slot = 3'd0; w.scene_bypass = 8'hFF; w.scene_solo = 4'd8;
    send_word(w);
    w = blank_word(FN_LDSLOT); w.slot = 3'd1; w.scene_solo = 4'd15;   // empties slot
    send_word(w);
    w = blank_word(FN_RECALL); w.slot = 3'd1; send_word(w);            // empty slot
    w = blank_word(FN_RECALL); w.slot = 3'd0; send_word(w);
    w = blank_word(FN_TSTART); w.stage = 3'd0; w.action_kind = KIND_BYP; send_word(w);
    w = blank_word(FN_TSTART); w.stage = 3'd7; w.action_kind = KIND_SOLO; send_word(w);
    w = blank_word(FN_TSTART); w.stage = 3'd3; w.action_kind = 2'd0; send_word(w);
    w = blank_word(FN_TSTART); w.stage = 3'd3; w.action_kind = 2'd3; send_word(w);
    w = blank_word(FN_STORE); w.slot = 3'd7; send_word(w);
    w = blank_word(FN_TCANCEL); w.stage = 3'd0; send_word(w);
    send_word(blank_word(FN_TAKEOVER));
    // a step as long as the field allows, crossed by one maximal tick
    w = blank_word(FN_LDSTEP); w.step_index = 4'd0; w.step_scene = 4'b1000;
    w.duration_frames = 32'hFFFF_FFFF; send_word(w);
    send_word(blank_word(FN_PLAY));
    w = blank_word(FN_TICK); w.tick_frames = 32'hFFFF_FFFF; send_word(w);
    w = blank_word(FN_TICK); w.tick_frames = 32'd0; send_word(w);
    send_word(blank_word(FN_STOP));
    send_word(blank_word(FN_RESET));
    send_word(blank_word(FN_RESTORE));
    send_word(blank_word(4'd13));
    send_word(blank_word(4'd15));

    // random phases over several register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_phase(16, 1'b1, 8'h00);
        1: set_phase(1, 1'b0, 8'hFF);
        2: set_phase(0, 1'b1, 8'($urandom));
        3: set_phase(31, 1'b0, 8'($urandom));
        4: set_phase($urandom_range(1, 16), 1'b1, 8'($urandom));
        default: set_phase(5, 1'b1, 8'hAA);
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 2 && n == 40) hold_request = 1;        // long receiver hold-off
        if (ph == 3 && n == 60) wait_drained();          // sender waits for all results
        send_word(random_word());
      end
    end

    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
